// File: rtl/core/tti_pkg.sv
// Shared types, constants and the character-to-digit function for the text-to-integer parser.
`default_nettype none

package tti_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned BASE_W   = 6;
   localparam int unsigned ACC_W    = 32;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned MAC_W    = ACC_W + BASE_W;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_B  = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

   localparam logic [CHAR_W-1:0] DIGIT_NONE = 8'hFF;
   localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

   localparam logic [ACC_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [ACC_W-1:0] VAL_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      PH_WS     = 3'd0,
      PH_SIGNED = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_DONE   = 3'd4
   } tti_phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } tti_req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic                    overflow;
      logic                    any_digits;
      logic [OFFSET_W-1:0]     end_offset;
   } tti_rsp_type;

   typedef struct packed {
      tti_phase_type       phase;
      logic                negative;
      logic [BASE_W-1:0]   active_base;
      logic [ACC_W-1:0]    accumulator;
      logic                saw_digit;
      logic                overflowed;
      logic [OFFSET_W-1:0] position;
   } tti_state_type;

   localparam tti_state_type STATE_RESET = '{
      phase:       PH_WS,
      negative:    1'b0,
      active_base: '0,
      accumulator: '0,
      saw_digit:   1'b0,
      overflowed:  1'b0,
      position:    '0
   };

   // 0-9, A-Z and a-z map to 0..35; anything else is not a digit
   function automatic logic [CHAR_W-1:0] tti_digit_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = DIGIT_NONE;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
         d = c - CH_UC_A + LETTER_OFS;
      end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
         d = c - CH_LC_A + LETTER_OFS;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tti_step.sv
// Per-character parse step: next parse state, result strobe and result fields.
`default_nettype none

module tti_step #(
   parameter int unsigned MAX_OFFSET = 4095
) (
   input  tti_pkg::tti_state_type state_cur,
   input  logic [5:0]             base_mode,
   input  tti_pkg::tti_req_type   item,
   output tti_pkg::tti_state_type state_nxt,
   output logic                   emit,
   output tti_pkg::tti_rsp_type   result
);
   import tti_pkg::*;

   localparam int unsigned LimInt = (MAX_OFFSET > 4095) ? 4095 : MAX_OFFSET;
   localparam logic [OFFSET_W-1:0] OffsetLim = OFFSET_W'(LimInt);

   logic [CHAR_W-1:0]   dval;
   logic [BASE_W-1:0]   dbase;
   logic [BASE_W-1:0]   auto_oct;
   logic [BASE_W-1:0]   auto_dec;
   logic [MAC_W-1:0]    mac;
   logic [MAC_W-1:0]    limit;
   logic [OFFSET_W-1:0] pos_inc;
   logic                digit_ok;
   logic                bm_auto;
   logic                bm_hex;
   logic                bm_bin;
   logic                is_space;
   logic                is_x;
   logic                is_b;
   logic                first_chr;
   logic                do_digit;
   logic                off_adv;
   tti_state_type       ns;

   assign bm_auto  = base_mode == BASE_AUTO;
   assign bm_hex   = base_mode == BASE_HEX;
   assign bm_bin   = base_mode == BASE_BIN;
   assign auto_oct = bm_auto ? BASE_OCT : base_mode;
   assign auto_dec = bm_auto ? BASE_DEC : base_mode;

   assign is_space = item.ch == CH_SPACE || item.ch == CH_TAB || item.ch == CH_NL;
   assign is_x     = item.ch == CH_LC_X || item.ch == CH_UC_X;
   assign is_b     = item.ch == CH_LC_B || item.ch == CH_UC_B;

   assign dval = tti_digit_value(item.ch);

   always_comb begin
      case (state_cur.phase)
         PH_DIGITS: dbase = state_cur.active_base;
         PH_ZERO:   dbase = auto_oct;
         default:   dbase = auto_dec;
      endcase
   end

   assign digit_ok = dval < {2'b00, dbase};
   assign mac      = MAC_W'(state_cur.accumulator) * MAC_W'(dbase) + MAC_W'(dval);
   assign limit    = state_cur.negative ? MAC_W'(VAL_MIN) : MAC_W'(VAL_MAX);
   assign pos_inc  = (state_cur.position < OffsetLim) ? state_cur.position + 1'b1
                                                      : state_cur.position;

   always_comb begin
      ns          = state_cur;
      ns.position = pos_inc;
      emit        = 1'b0;
      off_adv     = 1'b0;
      first_chr   = 1'b0;
      do_digit    = 1'b0;

      unique case (state_cur.phase)
         PH_WS: begin
            if (is_space) begin
               emit = item.last;
            end else if (item.ch == CH_MINUS || item.ch == CH_PLUS) begin
               ns.negative = item.ch == CH_MINUS;
               ns.phase    = PH_SIGNED;
               emit        = item.last;
            end else begin
               first_chr = 1'b1;
            end
         end
         PH_SIGNED: first_chr = 1'b1;
         PH_ZERO: begin
            if (is_x && (bm_auto || bm_hex)) begin
               ns.active_base = BASE_HEX;
               ns.phase       = PH_DIGITS;
               emit           = item.last;
            end else if (is_b && (bm_auto || bm_bin)) begin
               ns.active_base = BASE_BIN;
               ns.phase       = PH_DIGITS;
               emit           = item.last;
            end else begin
               // the leading zero counts as a digit
               ns.active_base = auto_oct;
               ns.saw_digit   = 1'b1;
               ns.accumulator = '0;
               ns.phase       = PH_DIGITS;
               do_digit       = 1'b1;
            end
         end
         PH_DIGITS: do_digit = 1'b1;
         PH_DONE:   ;
         default:   ;
      endcase

      if (first_chr) begin
         if (item.ch == CH_ZERO && (bm_auto || bm_hex || bm_bin)) begin
            ns.phase = PH_ZERO;
            if (item.last) begin
               ns.active_base = auto_oct;
               ns.saw_digit   = 1'b1;
               ns.accumulator = '0;
               emit           = 1'b1;
               off_adv        = 1'b1;
            end
         end else begin
            ns.active_base = auto_dec;
            ns.phase       = PH_DIGITS;
            do_digit       = 1'b1;
         end
      end

      if (do_digit) begin
         if (!digit_ok) begin
            emit = 1'b1;
         end else begin
            if (ns.overflowed || mac > limit) begin
               ns.overflowed = 1'b1;
            end else begin
               ns.accumulator = mac[ACC_W-1:0];
            end
            ns.saw_digit = 1'b1;
            if (item.last) begin
               emit    = 1'b1;
               off_adv = 1'b1;
            end
         end
      end

      if (emit) begin
         ns.phase = PH_DONE;
      end

      if (ns.overflowed) begin
         result.value = $signed(ns.negative ? VAL_MIN : VAL_MAX);
      end else begin
         result.value = $signed(ns.negative ? (ACC_W'(0) - ns.accumulator) : ns.accumulator);
      end
      result.overflow   = ns.overflowed;
      result.any_digits = ns.saw_digit;
      result.end_offset = !ns.saw_digit ? '0 : (off_adv ? pos_inc : state_cur.position);

      // end of string: parse state back to reset, base register untouched
      state_nxt = item.last ? STATE_RESET : ns;
   end

endmodule

`default_nettype wire

// File: rtl/core/text_to_integer_parser.sv
// Top level of the streaming text-to-integer parser.
//
// Characters arrive on the req_ channel, one per transaction, with last
// marking the final character of a string. Each string gives exactly one
// transaction on the rsp_ channel: the signed value (saturated on
// overflow), the overflow flag, whether any digit was taken and the end
// offset. The result leaves on the character that ends the parse; later
// characters up to last are consumed silently.
// csr_write_enable/csr_write_data set the base (0 = automatic); write it
// only while no string is in flight.
// A character accepted into the input register feeds the step logic, whose
// result is registered in the result register. Throughput: one character
// per cycle unless rsp_stall holds a waiting result, set by the single
// multiply-add on the accumulator between the input and result registers.
// Reset clears the parse state, the base and both registers' valid flags.
// When rsp_stall holds a waiting result, the result register keeps its
// transaction and the input register keeps its character; req_stall is
// high only while the input register is full and held, so an empty one takes one more.
`default_nettype none

module text_to_integer_parser #(
   parameter int unsigned MAX_OFFSET = 4095
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tti_pkg::tti_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tti_pkg::tti_rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic [5:0]           csr_write_data
);
   import tti_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   tti_req_type       in_data_ff;
   tti_req_type       in_data_in;
   tti_state_type     state_ff;
   tti_state_type     state_in;
   logic [BASE_W-1:0] base_mode_ff;
   logic [BASE_W-1:0] base_mode_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   tti_rsp_type       rsp_data_ff;
   tti_rsp_type       rsp_data_in;

   tti_state_type     step_state;
   tti_rsp_type       step_result;
   logic              step_emit;
   logic              advance;
   logic              req_take;

   tti_step #(
      .MAX_OFFSET(MAX_OFFSET)
   ) u_step (
      .state_cur(state_ff),
      .base_mode(base_mode_ff),
      .item     (in_data_ff),
      .state_nxt(step_state),
      .emit     (step_emit),
      .result   (step_result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      state_in     = state_ff;
      base_mode_in = base_mode_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_enable) begin
         base_mode_in = csr_write_data;
      end

      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         state_in = step_state;
         if (step_emit) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = step_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         base_mode_ff <= BASE_AUTO;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         base_mode_ff <= base_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no digits means an all-zero result
   a_no_digits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.any_digits |->
         rsp_data_ff.value == 0 && !rsp_data_ff.overflow && rsp_data_ff.end_offset == '0)
      else $error("result without digits is not zero");

   // saturated value on overflow
   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.overflow |->
         rsp_data_ff.value == $signed(VAL_MAX) || rsp_data_ff.value == $signed(VAL_MIN))
      else $error("overflowed result not saturated");

   // the last character of a string returns the parser to its start
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.last |=> state_ff == STATE_RESET)
      else $error("parse state not cleared after last character");

   // at most one result per string
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.phase == PH_DONE |-> !step_emit)
      else $error("second result for one string");

   // a result transaction needs a processed character
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance) && $past(step_emit))
      else $error("result raised without a processed character");

endmodule

`default_nettype wire
